>>> rtl/rfaf_pkg.sv
// ----------------------------------------------------------------------------
// rfaf_pkg - received frame acceptance filter package
// Types, register indexes and protocol byte values shared by the filter.
// ----------------------------------------------------------------------------
package rfaf_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned POS_W      = 9;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_KIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_J1708_KIND   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_MID = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PID = 3'd6;

  typedef enum logic [1:0] {
    FILT_PASS    = 2'd0,
    FILT_KEYWORD = 2'd1,
    FILT_J1708   = 2'd2,
    FILT_SPARE   = 2'd3
  } filter_kind_e;

  localparam logic [2:0] J_NONE  = 3'd0;
  localparam logic [2:0] J_REPLY = 3'd1;
  localparam logic [2:0] J_M80   = 3'd2;
  localparam logic [2:0] J_MFF   = 3'd3;
  localparam logic [2:0] J_MFE   = 3'd4;
  localparam logic [2:0] J_MC3   = 3'd5;

  // Protocol byte values
  localparam logic [7:0] B_SINGLE   = 8'h07;
  localparam logic [7:0] B_MID_BIAS = 8'h40;
  localparam logic [7:0] B_MULTI    = 8'h80;
  localparam logic [7:0] B_ACK      = 8'hC0;
  localparam logic [7:0] B_SIX      = 8'h06;
  localparam logic [7:0] B_75       = 8'h75;
  localparam logic [7:0] B_85       = 8'h85;
  localparam logic [7:0] B_64       = 8'h64;
  localparam logic [7:0] B_96       = 8'h96;
  localparam logic [7:0] B_C2       = 8'hC2;
  localparam logic [7:0] B_FE       = 8'hFE;
  localparam logic [7:0] B_AC       = 8'hAC;
  localparam logic [7:0] B_C4       = 8'hC4;
  localparam logic [7:0] B_FF       = 8'hFF;

endpackage

>>> rtl/rfaf_if.sv
// ----------------------------------------------------------------------------
// rfaf_if - channel interfaces of the frame acceptance filter
// Byte input, verdict output and configuration write channels.
// ----------------------------------------------------------------------------
interface rfaf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface rfaf_out_if;
  logic valid;
  logic ready;
  logic discard;

  modport source (output valid, output discard, input ready);
  modport sink   (input valid, input discard, output ready);
endinterface

interface rfaf_cfg_if import rfaf_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/received_frame_acceptance_filter.sv
// ----------------------------------------------------------------------------
// received_frame_acceptance_filter - per-frame keyword / J1708 reply filter
// Consumes frame bytes and issues one discard verdict per frame.
// ----------------------------------------------------------------------------
// The verdict is in the output register in the cycle after the last
// byte's beat is accepted.
// Throughput: one byte beat per cycle; the byte input stalls only while a
//   verdict waits in the output register and the sink holds it off.
// Reset: rst_ni clears the configuration registers, the frame tracking and the
//   output valid at once, but not the discard bit; the block is ready right after reset.
module received_frame_acceptance_filter
  import rfaf_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  rfaf_in_if.sink           frame_i,
  rfaf_out_if.source        verdict_o,
  rfaf_cfg_if.sink          cfg_i
);

  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned KLEN_W = 4;

  // Configuration registers
  logic [1:0]                 filter_kind_q;
  logic [7:0]                 key_offset_q;
  logic [KLEN_W-1:0]          key_length_q;
  logic [KEY_BYTES-1:0][7:0]  key_q;
  logic [2:0]                 j1708_kind_q;
  logic [7:0]                 mid_q;
  logic [7:0]                 pid_q;

  // Frame tracking
  logic [POS_W-1:0]           pos_q,  pos_d;
  logic                       mism_q, mism_d;
  logic [2:0][7:0]            head_q, head_d;
  logic [1:0]                 hcnt_q, hcnt_d;

  // Output register
  logic                       out_valid_q;
  logic                       discard_q, discard_d;

  logic                       in_acc;
  logic                       cfg_acc;

  // Take a new byte whenever the output register is free or draining.
  assign frame_i.ready   = !out_valid_q || verdict_o.ready;
  assign in_acc          = frame_i.valid && frame_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign cfg_acc         = cfg_i.valid && cfg_i.ready;
  assign verdict_o.valid = out_valid_q;
  assign verdict_o.discard = discard_q;

  // ---------------------------------------------------------------------------
  // Configuration writes; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_kind_q <= '0;
      key_offset_q  <= '0;
      key_length_q  <= '0;
      key_q         <= '0;
      j1708_kind_q  <= '0;
      mid_q         <= '0;
      pid_q         <= '0;
    end else if (cfg_acc) begin
      unique case (cfg_i.index)
        REG_FILTER_KIND:  filter_kind_q <= cfg_i.data[1:0];
        REG_KEY_OFFSET:   key_offset_q  <= cfg_i.data[7:0];
        REG_KEY_LENGTH:   key_length_q  <= cfg_i.data[KLEN_W-1:0];
        REG_KEY_BYTES:    key_q         <= cfg_i.data[KEY_BYTES*8-1:0];
        REG_J1708_KIND:   j1708_kind_q  <= cfg_i.data[2:0];
        REG_EXPECTED_MID: mid_q         <= cfg_i.data[7:0];
        REG_EXPECTED_PID: pid_q         <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Per-byte work: keyword window compare, head capture, verdict.
  // ---------------------------------------------------------------------------
  logic [KLEN_W-1:0] klen;
  logic [POS_W-1:0]  key_end;
  logic [POS_W-1:0]  key_rel;
  logic              in_window;
  logic [7:0]        key_byte;
  logic [POS_W:0]    frame_len;
  logic              too_short;
  logic              j_ok;
  logic [7:0]        mid_less;

  // Head byte i is present and equal to v.
  function automatic logic head_is(input logic [2:0][7:0] h, input logic [1:0] cnt,
                                   input logic [1:0] idx, input logic [7:0] v);
    return (idx < cnt) && (h[idx] == v);
  endfunction

  always_comb begin
    // Clamp an overlong keyword length to the stored key.
    klen = (key_length_q > KLEN_W'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : key_length_q;
    key_end   = POS_W'(key_offset_q) + POS_W'(klen);
    in_window = (pos_q >= POS_W'(key_offset_q)) && (pos_q < key_end);
    key_rel   = pos_q - POS_W'(key_offset_q);
    key_byte  = key_q[key_rel[KIDX_W-1:0]];

    mism_d = mism_q || (in_window && (key_byte != frame_i.frame_byte));

    head_d = head_q;
    hcnt_d = hcnt_q;
    if (hcnt_q != 2'd3) begin
      head_d[hcnt_q] = frame_i.frame_byte;
      hcnt_d         = hcnt_q + 2'd1;
    end

    pos_d = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);

    frame_len = {1'b0, pos_q} + (POS_W+1)'(1);
    too_short = frame_len < {1'b0, key_end};

    mid_less = mid_q - B_MID_BIAS;
    unique case (j1708_kind_q)
      J_REPLY: j_ok =
          ((mid_q >= B_MID_BIAS) && head_is(head_d, hcnt_d, 2'd0, B_SINGLE)
            && head_is(head_d, hcnt_d, 2'd1, mid_less)
            && head_is(head_d, hcnt_d, 2'd2, pid_q))
       || (head_is(head_d, hcnt_d, 2'd0, B_MULTI) && head_is(head_d, hcnt_d, 2'd1, B_ACK))
       || (head_is(head_d, hcnt_d, 2'd0, B_SIX) && head_is(head_d, hcnt_d, 2'd1, B_75)
            && head_is(head_d, hcnt_d, 2'd2, B_85))
       || (head_is(head_d, hcnt_d, 2'd0, B_SIX) && head_is(head_d, hcnt_d, 2'd1, B_64)
            && head_is(head_d, hcnt_d, 2'd2, B_96));
      J_M80: j_ok = head_is(head_d, hcnt_d, 2'd0, mid_q)
          && (head_is(head_d, hcnt_d, 2'd1, B_ACK) || head_is(head_d, hcnt_d, 2'd1, B_C2));
      J_MFF: j_ok = head_is(head_d, hcnt_d, 2'd0, mid_q)
          && head_is(head_d, hcnt_d, 2'd1, B_FF) && head_is(head_d, hcnt_d, 2'd2, pid_q);
      J_MFE: j_ok = head_is(head_d, hcnt_d, 2'd0, mid_q)
          && (head_is(head_d, hcnt_d, 2'd1, B_ACK)
              || (head_is(head_d, hcnt_d, 2'd1, B_FE) && head_is(head_d, hcnt_d, 2'd2, B_AC)));
      J_MC3: j_ok = head_is(head_d, hcnt_d, 2'd0, mid_q) && head_is(head_d, hcnt_d, 2'd1, B_C4);
      default: j_ok = 1'b0;   // no pattern, or an unused code: reject
    endcase

    unique case (filter_kind_e'(filter_kind_q))
      FILT_KEYWORD: discard_d = too_short || mism_d;
      FILT_J1708:   discard_d = !j_ok;
      default:      discard_d = 1'b0;   // pass mode and the spare code
    endcase
  end

  // Advance the frame tracking on every beat; clear it after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      mism_q <= 1'b0;
      head_q <= '0;
      hcnt_q <= '0;
    end else if (in_acc) begin
      if (frame_i.last_byte) begin
        pos_q  <= '0;
        mism_q <= 1'b0;
        head_q <= '0;
        hcnt_q <= '0;
      end else begin
        pos_q  <= pos_d;
        mism_q <= mism_d;
        head_q <= head_d;
        hcnt_q <= hcnt_d;
      end
    end
  end

  // Verdict register: load on a last byte, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && frame_i.last_byte) begin
      out_valid_q <= 1'b1;
    end else if (verdict_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && frame_i.last_byte) begin
      discard_q <= discard_d;
    end
  end

endmodule

>>> rtl/rfaf_checker.sv
// ----------------------------------------------------------------------------
// rfaf_checker - port-level checks for the frame acceptance filter
// Watches the byte, verdict and configuration channels over time.
// ----------------------------------------------------------------------------
module rfaf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic in_last_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_discard_i,
  input logic cfg_ready_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A last byte always yields a verdict in the next cycle.
  a_last_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> out_valid_i)
    else $error("no verdict after last byte");

  // A middle byte never produces a verdict of its own.
  a_mid_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_last_i && (!out_valid_i || out_ready_i) |=> !out_valid_i)
    else $error("verdict after a middle byte");

  // Byte input is held off exactly while a verdict is stalled.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("byte ready does not follow verdict stall");

  // A stalled verdict holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_discard_i))
    else $error("stalled verdict changed");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration channel stalled");

endmodule

bind received_frame_acceptance_filter rfaf_checker u_rfaf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (frame_i.valid),
  .in_ready_i    (frame_i.ready),
  .in_last_i     (frame_i.last_byte),
  .out_valid_i   (verdict_o.valid),
  .out_ready_i   (verdict_o.ready),
  .out_discard_i (verdict_o.discard),
  .cfg_ready_i   (cfg_i.ready)
);
